// File: hw/rtl/scl_pkg.sv
// scl_pkg: shared constants, widths and types for the shuffled combined LCG bank.
// Used by scl_schrage, scl_slot and shuffled_combined_lcg_bank_core; no dependencies.
`timescale 1ns / 1ps

package scl_pkg;

   // Bank size and shuffle table depth
   localparam int NUM_GENERATORS = 3;
   localparam int TABLE_DEPTH    = 32;

   // Field widths
   localparam int VAL_W = 31;
   localparam int GEN_W = 2;

   // Generator and table addressing
   localparam int GEN_AW        = (NUM_GENERATORS > 1) ? $clog2(NUM_GENERATORS) : 1;
   localparam int IDX_W         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int QUO_W         = IDX_W + 1;
   localparam int TAB_DEPTH_ALL = NUM_GENERATORS * TABLE_DEPTH;
   localparam int TAB_AW        = (TAB_DEPTH_ALL > 1) ? $clog2(TAB_DEPTH_ALL) : 1;

   // Warm-up length of a seed transfer
   localparam int WARMUP = TABLE_DEPTH + 8;
   localparam int CNT_W  = $clog2(WARMUP);

   // LCG constants (Schrage form: m = a*q + r)
   localparam logic [VAL_W-1:0] MOD_A   = 31'd2147483563;
   localparam logic [VAL_W-1:0] MOD_B   = 31'd2147483399;
   localparam logic [VAL_W-1:0] TOP_VAL = MOD_A - 31'd1;
   localparam logic [VAL_W-1:0] SEED_B  = 31'd123456789;
   localparam logic [15:0]      MUL_A   = 16'd40014;
   localparam logic [15:0]      MUL_B   = 16'd40692;
   localparam logic [15:0]      QUO_A   = 16'd53668;
   localparam logic [15:0]      QUO_B   = 16'd52774;
   localparam logic [13:0]      REM_A   = 14'd12211;
   localparam logic [13:0]      REM_B   = 14'd3791;

   // Reciprocals for x / q: k0 = (x * recip) >> RECIP_SHIFT, low by at most one
   localparam int RECIP_W     = 32;
   localparam int RECIP_SHIFT = 47;
   localparam int K_W         = 16;
   localparam int PROD_W      = VAL_W + RECIP_W;
   localparam logic [63:0] RECIP_A_WIDE = (64'd1 << RECIP_SHIFT) / 64'(QUO_A);
   localparam logic [63:0] RECIP_B_WIDE = (64'd1 << RECIP_SHIFT) / 64'(QUO_B);
   localparam logic [RECIP_W-1:0] RECIP_A = RECIP_A_WIDE[RECIP_W-1:0];
   localparam logic [RECIP_W-1:0] RECIP_B = RECIP_B_WIDE[RECIP_W-1:0];

   // Slot divider: last_output / SLOT_DIV, reciprocal again low by at most one
   localparam logic [63:0] SLOT_DIV_WIDE = 64'(TOP_VAL) / 64'(TABLE_DEPTH) + 64'd1;
   localparam logic [VAL_W-1:0] SLOT_DIV = SLOT_DIV_WIDE[VAL_W-1:0];
   localparam int SLOT_SHIFT   = 40;
   localparam int SLOT_RECIP_W = 17;
   localparam logic [63:0] SLOT_RECIP_WIDE = (64'd1 << SLOT_SHIFT) / SLOT_DIV_WIDE;
   localparam logic [SLOT_RECIP_W-1:0] SLOT_RECIP = SLOT_RECIP_WIDE[SLOT_RECIP_W-1:0];

   // Opcodes
   localparam logic OP_SEED = 1'b0;
   localparam logic OP_DRAW = 1'b1;

   // Per-generator state word
   typedef struct packed {
      logic [VAL_W-1:0] first_lcg;
      logic [VAL_W-1:0] second_lcg;
      logic [VAL_W-1:0] last_output;
   } gen_state_type;

   localparam gen_state_type GST_RESET = '{
      first_lcg:   31'd1,
      second_lcg:  SEED_B,
      last_output: '0
   };

   // Step request into a Schrage unit
   typedef struct packed {
      logic start;
      logic sel_b;
   } lcg_req_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED_ISSUE,
      ST_SEED_WAIT,
      ST_DRAW_READ,
      ST_DRAW_WAIT
   } ctl_state_type;

endpackage

// File: hw/rtl/scl_schrage.sv
// scl_schrage: four-stage pipelined Schrage step y = a*(x mod q) - (x/q)*r (+m if negative).
// Selects the first or second LCG constant set per request; depends on scl_pkg.
`timescale 1ns / 1ps

module scl_schrage (
   input  logic                        clock,
   input  logic                        reset,
   input  scl_pkg::lcg_req_type        req,
   input  logic [scl_pkg::VAL_W-1:0]   x_in,
   output logic                        done,
   output logic [scl_pkg::VAL_W-1:0]   y
);

   // Stage 1: quotient estimate by reciprocal
   logic [scl_pkg::RECIP_W-1:0] recip_sel;
   logic [scl_pkg::PROD_W-1:0]  prod0;
   logic                        p1_vld_ff;
   logic                        p1_sel_ff;
   logic [scl_pkg::VAL_W-1:0]   p1_x_ff;
   logic [scl_pkg::K_W-1:0]     p1_k_ff;

   always_comb begin
      recip_sel = req.sel_b ? scl_pkg::RECIP_B : scl_pkg::RECIP_A;
      prod0     = scl_pkg::PROD_W'(x_in) * scl_pkg::PROD_W'(recip_sel);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff <= req.start;
      end
   end

   always_ff @(posedge clock) begin
      p1_sel_ff <= req.sel_b;
      p1_x_ff   <= x_in;
      p1_k_ff   <= prod0[scl_pkg::RECIP_SHIFT +: scl_pkg::K_W];
   end

   // Stage 2: raw remainder x - k0*q, below 2q
   logic [15:0]             quo1;
   logic [31:0]             kq1;
   logic [31:0]             rem1;
   logic                    p2_vld_ff;
   logic                    p2_sel_ff;
   logic [16:0]             p2_rem_ff;
   logic [scl_pkg::K_W-1:0] p2_k_ff;

   always_comb begin
      quo1 = p1_sel_ff ? scl_pkg::QUO_B : scl_pkg::QUO_A;
      kq1  = 32'(p1_k_ff) * 32'(quo1);
      rem1 = 32'(p1_x_ff) - kq1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_vld_ff <= 1'b0;
      end else begin
         p2_vld_ff <= p1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p2_sel_ff <= p1_sel_ff;
      p2_rem_ff <= rem1[16:0];
      p2_k_ff   <= p1_k_ff;
   end

   // Stage 3: fix quotient, form a*rem and k*r
   logic [15:0]             quo2;
   logic [15:0]             mul2;
   logic [13:0]             rr2;
   logic [16:0]             rem2;
   logic [scl_pkg::K_W-1:0] k2;
   logic [31:0]             pa2;
   logic [31:0]             pk2;
   logic                    p3_vld_ff;
   logic                    p3_sel_ff;
   logic [30:0]             p3_pa_ff;
   logic [30:0]             p3_pk_ff;

   always_comb begin
      quo2 = p2_sel_ff ? scl_pkg::QUO_B : scl_pkg::QUO_A;
      mul2 = p2_sel_ff ? scl_pkg::MUL_B : scl_pkg::MUL_A;
      rr2  = p2_sel_ff ? scl_pkg::REM_B : scl_pkg::REM_A;
      rem2 = p2_rem_ff;
      k2   = p2_k_ff;
      if (p2_rem_ff >= 17'(quo2)) begin
         rem2 = p2_rem_ff - 17'(quo2);
         k2   = p2_k_ff + 16'd1;
      end
      pa2 = 32'(rem2[15:0]) * 32'(mul2);
      pk2 = 32'(k2) * 32'(rr2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_vld_ff <= 1'b0;
      end else begin
         p3_vld_ff <= p2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p3_sel_ff <= p2_sel_ff;
      p3_pa_ff  <= pa2[30:0];
      p3_pk_ff  <= pk2[30:0];
   end

   // Stage 4: subtract, wrap by the modulus
   logic [scl_pkg::VAL_W-1:0] mod3;
   logic [31:0]               diff3;
   logic [31:0]               y_in;
   logic                      done_ff;
   logic [scl_pkg::VAL_W-1:0] y_ff;

   always_comb begin
      mod3  = p3_sel_ff ? scl_pkg::MOD_B : scl_pkg::MOD_A;
      diff3 = {1'b0, p3_pa_ff} - {1'b0, p3_pk_ff};
      y_in  = diff3[31] ? (diff3 + {1'b0, mod3}) : diff3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= p3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      y_ff <= y_in[scl_pkg::VAL_W-1:0];
   end

   assign done = done_ff;
   assign y    = y_ff;

endmodule

// File: hw/rtl/scl_slot.sv
// scl_slot: two-stage divide of the last output by the slot divider, saturated to the table.
// Reciprocal multiply plus one compare-and-correct step; depends on scl_pkg.
`timescale 1ns / 1ps

module scl_slot (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [scl_pkg::VAL_W-1:0]   value,
   output logic                        done,
   output logic [scl_pkg::IDX_W-1:0]   slot
);

   localparam int SPROD_W = scl_pkg::VAL_W + scl_pkg::SLOT_RECIP_W;
   localparam int REM_W   = scl_pkg::VAL_W + scl_pkg::QUO_W + 1;

   // Stage 1: quotient estimate
   logic [SPROD_W-1:0]              sprod;
   logic                            s1_vld_ff;
   logic [scl_pkg::VAL_W-1:0]       s1_v_ff;
   logic [scl_pkg::QUO_W-1:0]       s1_q_ff;

   assign sprod = SPROD_W'(value) * SPROD_W'(scl_pkg::SLOT_RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      s1_v_ff <= value;
      s1_q_ff <= sprod[scl_pkg::SLOT_SHIFT +: scl_pkg::QUO_W];
   end

   // Stage 2: correct by one, clamp to the last slot
   logic [REM_W-1:0]          kd2;
   logic [REM_W-1:0]          rem2;
   logic [scl_pkg::QUO_W-1:0] q2;
   logic [scl_pkg::IDX_W-1:0] slot_in;
   logic                      done_ff;
   logic [scl_pkg::IDX_W-1:0] slot_ff;

   always_comb begin
      kd2  = REM_W'(s1_q_ff) * REM_W'(scl_pkg::SLOT_DIV);
      rem2 = REM_W'(s1_v_ff) - kd2;
      q2   = s1_q_ff;
      if (rem2 >= REM_W'(scl_pkg::SLOT_DIV)) begin
         q2 = s1_q_ff + scl_pkg::QUO_W'(1);
      end
      if (q2 > scl_pkg::QUO_W'(scl_pkg::TABLE_DEPTH - 1)) begin
         slot_in = scl_pkg::IDX_W'(scl_pkg::TABLE_DEPTH - 1);
      end else begin
         slot_in = q2[scl_pkg::IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign done = done_ff;
   assign slot = slot_ff;

endmodule

// File: hw/rtl/shuffled_combined_lcg_bank_core.sv
// Bank of combined two-LCG generators with a Bays-Durham shuffle table per generator.
// Holds the state and table memories and the sequencer; uses scl_pkg, scl_schrage, scl_slot.
`timescale 1ns / 1ps

// A transfer is taken when start is high and busy is low; busy rises the next cycle.
// A draw holds busy high from ST_DRAW_READ until its write-back, so a new transfer is
// taken only once the draw is done. Its result appears on the rsp_ ports for exactly
// one cycle, marked by rsp_strobe and driven from result registers; the receiver cannot
// stall, so it must take the result in that cycle. A seed gives no result and holds
// busy high through the issue state and then while each of the WARMUP warm-up steps
// passes once through the four-stage Schrage pipeline. A draw first reads the state
// memory, then passes through that same pipeline; the write-back lands on the edge that
// ends busy. A transfer that names a generator outside the bank is taken and dropped
// without raising busy. After reset, a generator that has not been seeded starts from
// its reset state (zeroed table).

module shuffled_combined_lcg_bank_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_opcode,
   input  logic [scl_pkg::GEN_W-1:0]   req_generator,
   input  logic [scl_pkg::VAL_W-1:0]   req_seed_value,
   output logic                        rsp_strobe,
   output logic [scl_pkg::VAL_W-1:0]   rsp_random_value,
   output logic [scl_pkg::GEN_W-1:0]   rsp_from_generator
);

   // Sequencer state and item registers
   scl_pkg::ctl_state_type            ctl_state_ff;
   scl_pkg::ctl_state_type            ctl_state_in;
   logic [scl_pkg::GEN_W-1:0]         gen_ff;
   logic [scl_pkg::VAL_W-1:0]         seed_ff;
   logic [scl_pkg::VAL_W-1:0]         seed_in;
   logic [scl_pkg::CNT_W-1:0]         cnt_ff;
   logic [scl_pkg::TAB_AW-1:0]        tab_addr_ff;

   // Transfer decode
   logic                              accept;
   logic                              gen_ok;
   logic                              accept_ok;
   logic [scl_pkg::GEN_AW-1:0]        req_gen_idx;
   logic [scl_pkg::GEN_AW-1:0]        gen_idx;
   logic [scl_pkg::TAB_AW-1:0]        tab_base;

   assign accept      = start && !busy;
   assign gen_ok      = 32'(req_generator) < 32'(scl_pkg::NUM_GENERATORS);
   assign accept_ok   = accept && gen_ok;
   assign req_gen_idx = scl_pkg::GEN_AW'(req_generator);
   assign gen_idx     = scl_pkg::GEN_AW'(gen_ff);
   assign tab_base    = scl_pkg::TAB_AW'(32'(gen_idx) * 32'(scl_pkg::TABLE_DEPTH));

   // Seed clamp: zero taken as one, large values held at the top
   always_comb begin
      if (req_seed_value == '0) begin
         seed_in = scl_pkg::VAL_W'(1);
      end else if (req_seed_value > scl_pkg::TOP_VAL) begin
         seed_in = scl_pkg::TOP_VAL;
      end else begin
         seed_in = req_seed_value;
      end
   end

   // Step units and slot divider
   scl_pkg::lcg_req_type              a_req;
   scl_pkg::lcg_req_type              b_req;
   logic [scl_pkg::VAL_W-1:0]         a_x;
   logic [scl_pkg::VAL_W-1:0]         a_y;
   logic [scl_pkg::VAL_W-1:0]         b_y;
   logic                              a_done;
   logic                              b_done;
   logic                              slot_start;
   logic                              slot_done;
   logic [scl_pkg::IDX_W-1:0]         slot_idx;
   scl_pkg::gen_state_type            cur;

   scl_schrage u_lcg_a (
      .clock (clock),
      .reset (reset),
      .req   (a_req),
      .x_in  (a_x),
      .done  (a_done),
      .y     (a_y)
   );

   scl_schrage u_lcg_b (
      .clock (clock),
      .reset (reset),
      .req   (b_req),
      .x_in  (cur.second_lcg),
      .done  (b_done),
      .y     (b_y)
   );

   scl_slot u_slot (
      .clock (clock),
      .reset (reset),
      .start (slot_start),
      .value (cur.last_output),
      .done  (slot_done),
      .slot  (slot_idx)
   );

   // Memories: per-generator state and the shuffle tables
   scl_pkg::gen_state_type            gst_mem [scl_pkg::NUM_GENERATORS];
   logic [scl_pkg::NUM_GENERATORS-1:0] gst_vld_ff;
   scl_pkg::gen_state_type            gst_rd_ff;
   logic                              gst_rd_vld_ff;
   logic                              gst_wr_en;
   scl_pkg::gen_state_type            gst_wr_data;

   logic [scl_pkg::VAL_W-1:0]         tab_mem [scl_pkg::TAB_DEPTH_ALL];
   logic [scl_pkg::TAB_DEPTH_ALL-1:0] tab_vld_ff;
   logic [scl_pkg::VAL_W-1:0]         tab_rd_ff;
   logic                              tab_rd_vld_ff;
   logic                              tab_rd_en;
   logic [scl_pkg::TAB_AW-1:0]        tab_rd_addr;
   logic                              tab_wr_en;
   logic [scl_pkg::TAB_AW-1:0]        tab_wr_addr;

   // Entries never written read as reset values
   assign cur = gst_rd_vld_ff ? gst_rd_ff : scl_pkg::GST_RESET;

   // Draw result
   logic [scl_pkg::VAL_W-1:0]         tab_val;
   logic [31:0]                       diff;
   logic [31:0]                       draw_wide;
   logic [scl_pkg::VAL_W-1:0]         draw_val;

   always_comb begin
      tab_val   = tab_rd_vld_ff ? tab_rd_ff : '0;
      diff      = {1'b0, tab_val} - {1'b0, b_y};
      draw_wide = (diff[31] || diff == '0) ? (diff + {1'b0, scl_pkg::TOP_VAL}) : diff;
      draw_val  = draw_wide[scl_pkg::VAL_W-1:0];
   end

   // Sequencer: next state
   logic                              seed_fin;
   logic                              draw_fin;

   always_comb begin
      ctl_state_in = ctl_state_ff;
      case (ctl_state_ff)
         scl_pkg::ST_IDLE: begin
            if (accept_ok) begin
               ctl_state_in = (req_opcode == scl_pkg::OP_DRAW) ? scl_pkg::ST_DRAW_READ
                                                                : scl_pkg::ST_SEED_ISSUE;
            end
         end
         scl_pkg::ST_SEED_ISSUE: ctl_state_in = scl_pkg::ST_SEED_WAIT;
         scl_pkg::ST_SEED_WAIT: begin
            if (seed_fin) begin
               ctl_state_in = scl_pkg::ST_IDLE;
            end
         end
         scl_pkg::ST_DRAW_READ: ctl_state_in = scl_pkg::ST_DRAW_WAIT;
         scl_pkg::ST_DRAW_WAIT: begin
            if (draw_fin) begin
               ctl_state_in = scl_pkg::ST_IDLE;
            end
         end
         default: ctl_state_in = scl_pkg::ST_IDLE;
      endcase
   end

   // Sequencer: outputs
   always_comb begin
      busy        = 1'b1;
      a_req       = '{start: 1'b0, sel_b: 1'b0};
      b_req       = '{start: 1'b0, sel_b: 1'b1};
      a_x         = seed_ff;
      slot_start  = 1'b0;
      tab_rd_en   = 1'b0;
      tab_wr_en   = 1'b0;
      tab_wr_addr = tab_addr_ff;
      gst_wr_en   = 1'b0;
      gst_wr_data = '{first_lcg: a_y, second_lcg: b_y, last_output: draw_val};
      seed_fin    = 1'b0;
      draw_fin    = 1'b0;
      case (ctl_state_ff)
         scl_pkg::ST_IDLE: begin
            busy = 1'b0;
         end
         scl_pkg::ST_SEED_ISSUE: begin
            a_req.start = 1'b1;
         end
         scl_pkg::ST_SEED_WAIT: begin
            a_x = a_y;
            if (a_done) begin
               a_req.start = (cnt_ff != '0);
               seed_fin    = (cnt_ff == '0);
               tab_wr_en   = 32'(cnt_ff) < 32'(scl_pkg::TABLE_DEPTH);
               tab_wr_addr = tab_base + scl_pkg::TAB_AW'(cnt_ff);
               gst_wr_en   = (cnt_ff == '0);
               gst_wr_data = '{first_lcg: a_y, second_lcg: seed_ff, last_output: a_y};
            end
         end
         scl_pkg::ST_DRAW_READ: begin
            a_x         = cur.first_lcg;
            a_req.start = 1'b1;
            b_req.start = 1'b1;
            slot_start  = 1'b1;
         end
         scl_pkg::ST_DRAW_WAIT: begin
            tab_rd_en = slot_done;
            if (a_done) begin
               draw_fin  = 1'b1;
               tab_wr_en = 1'b1;
               gst_wr_en = 1'b1;
            end
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   assign tab_rd_addr = tab_base + scl_pkg::TAB_AW'(slot_idx);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_state_ff <= scl_pkg::ST_IDLE;
         cnt_ff       <= '0;
      end else begin
         ctl_state_ff <= ctl_state_in;
         if (accept_ok) begin
            cnt_ff <= scl_pkg::CNT_W'(scl_pkg::WARMUP - 1);
         end else if (ctl_state_ff == scl_pkg::ST_SEED_WAIT && a_done && cnt_ff != '0) begin
            cnt_ff <= cnt_ff - scl_pkg::CNT_W'(1);
         end
      end
   end

   // Item registers
   always_ff @(posedge clock) begin
      if (accept_ok) begin
         gen_ff  <= req_generator;
         seed_ff <= seed_in;
      end
      if (tab_rd_en) begin
         tab_addr_ff <= tab_rd_addr;
      end
   end

   // Valid bits of both memories
   always_ff @(posedge clock) begin
      if (reset) begin
         gst_vld_ff <= '0;
         tab_vld_ff <= '0;
      end else begin
         if (gst_wr_en) begin
            gst_vld_ff[gen_idx] <= 1'b1;
         end
         if (tab_wr_en) begin
            tab_vld_ff[tab_wr_addr] <= 1'b1;
         end
      end
   end

   // State memory: read at transfer, write back at the end of the item
   always_ff @(posedge clock) begin
      if (gst_wr_en) begin
         gst_mem[gen_idx] <= gst_wr_data;
      end
      if (accept_ok) begin
         gst_rd_ff     <= gst_mem[req_gen_idx];
         gst_rd_vld_ff <= gst_vld_ff[req_gen_idx];
      end
   end

   // Shuffle table memory
   always_ff @(posedge clock) begin
      if (tab_wr_en) begin
         tab_mem[tab_wr_addr] <= a_y;
      end
      if (tab_rd_en) begin
         tab_rd_ff     <= tab_mem[tab_rd_addr];
         tab_rd_vld_ff <= tab_vld_ff[tab_rd_addr];
      end
   end

   // Result register
   logic                              rsp_strobe_ff;
   logic [scl_pkg::VAL_W-1:0]         rsp_value_ff;
   logic [scl_pkg::GEN_W-1:0]         rsp_gen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= draw_fin;
      end
   end

   always_ff @(posedge clock) begin
      if (draw_fin) begin
         rsp_value_ff <= draw_val;
         rsp_gen_ff   <= gen_ff;
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_random_value   = rsp_value_ff;
   assign rsp_from_generator = rsp_gen_ff;

   // Checks
   a_strobe_after_draw: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(ctl_state_ff == scl_pkg::ST_DRAW_WAIT))
      else $error("result strobe without a finished draw");

   a_slot_in_draw: assert property (@(posedge clock) disable iff (reset)
      slot_done |-> (ctl_state_ff == scl_pkg::ST_DRAW_WAIT) && !a_done)
      else $error("slot index arrived outside the draw wait window");

   a_lcg_pair: assert property (@(posedge clock) disable iff (reset)
      b_done |-> a_done && (ctl_state_ff == scl_pkg::ST_DRAW_WAIT))
      else $error("second LCG finished apart from the first");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (ctl_state_ff == scl_pkg::ST_SEED_WAIT) |-> (32'(cnt_ff) < 32'(scl_pkg::WARMUP)))
      else $error("warm-up counter out of range");

   a_rsp_gen: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> (32'(rsp_gen_ff) < 32'(scl_pkg::NUM_GENERATORS)))
      else $error("result names a generator outside the bank");

endmodule

// File: dv/shuffled_combined_lcg_bank_core_tb.sv
// Self-checking testbench for shuffled_combined_lcg_bank_core: seeds and draws per generator,
// predicted by an in-bench combined LCG with shuffle table. Depends on scl_pkg and the core RTL.
`timescale 1ns / 1ps

module shuffled_combined_lcg_bank_core_tb;

   localparam int VAL_W     = scl_pkg::VAL_W;
   localparam int GEN_W     = scl_pkg::GEN_W;
   localparam int NUM_GEN   = scl_pkg::NUM_GENERATORS;
   localparam int SLOTS     = scl_pkg::TABLE_DEPTH;

   // Arithmetic of the two LCGs, kept independent of the RTL package
   localparam longint MOD_ONE   = 64'd2147483563;
   localparam longint MOD_TWO   = 64'd2147483399;
   localparam longint MULT_ONE  = 64'd40014;
   localparam longint MULT_TWO  = 64'd40692;
   localparam longint INIT_TWO  = 64'd123456789;
   localparam longint TOP_DRAW  = MOD_ONE - 1;
   localparam longint SLOT_SPAN = 1 + TOP_DRAW / SLOTS;

   localparam logic [GEN_W-1:0] NO_SUCH_GEN = '1;
   localparam logic [VAL_W-1:0] ALL_ONES    = '1;
   localparam int IDLE_LIMIT   = 4000;
   localparam int RANDOM_ITEMS = 1030;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic [GEN_W-1:0] gen;
   } draw_result_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_opcode;
   logic [GEN_W-1:0]  req_generator;
   logic [VAL_W-1:0]  req_seed_value;
   logic              rsp_strobe;
   logic [VAL_W-1:0]  rsp_random_value;
   logic [GEN_W-1:0]  rsp_from_generator;

   // Predictor state, one entry per generator
   longint lcg_one [NUM_GEN];
   longint lcg_two [NUM_GEN];
   longint prev_draw [NUM_GEN];
   longint shuffle_slots [NUM_GEN][SLOTS];

   draw_result_type pending_draws[$];
   int fail_count = 0;
   int idle_cycles = 0;

   shuffled_combined_lcg_bank_core dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_generator      (req_generator),
      .req_seed_value     (req_seed_value),
      .rsp_strobe         (rsp_strobe),
      .rsp_random_value   (rsp_random_value),
      .rsp_from_generator (rsp_from_generator)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // One multiplicative LCG step; exact modular product fits in 64 bits
   function automatic longint lcg_next(longint x, longint mult, longint modulus);
      return (x * mult) % modulus;
   endfunction

   task automatic clear_generators();
      for (int g = 0; g < NUM_GEN; g++) begin
         lcg_one[g]   = 1;
         lcg_two[g]   = INIT_TWO;
         prev_draw[g] = 0;
         for (int i = 0; i < SLOTS; i++) shuffle_slots[g][i] = 0;
      end
   endtask

   // Reload both LCGs, warm up the first one and fill the table top down
   task automatic seed_generator(int g, logic [VAL_W-1:0] seed_in);
      longint s;
      s = seed_in;
      if (s == 0) s = 1;
      if (s > TOP_DRAW) s = TOP_DRAW;
      lcg_one[g] = s;
      lcg_two[g] = s;
      for (int j = SLOTS + 7; j >= 0; j--) begin
         lcg_one[g] = lcg_next(lcg_one[g], MULT_ONE, MOD_ONE);
         if (j < SLOTS) shuffle_slots[g][j] = lcg_one[g];
      end
      prev_draw[g] = shuffle_slots[g][0];
   endtask

   // Advance both LCGs, pick a slot from the last output, refill it
   task automatic draw_number(int g);
      longint slot;
      longint v;
      draw_result_type r;
      lcg_one[g] = lcg_next(lcg_one[g], MULT_ONE, MOD_ONE);
      lcg_two[g] = lcg_next(lcg_two[g], MULT_TWO, MOD_TWO);
      slot = prev_draw[g] / SLOT_SPAN;
      if (slot > SLOTS - 1) slot = SLOTS - 1;
      v = shuffle_slots[g][slot] - lcg_two[g];
      shuffle_slots[g][slot] = lcg_one[g];
      if (v < 1) v += TOP_DRAW;
      prev_draw[g] = v;
      r.value = VAL_W'(v);
      r.gen   = GEN_W'(g);
      pending_draws.push_back(r);
   endtask

   // Present one command and hold it until the core takes the transfer.
   // start is left high; idle_for lowers it when a gap follows.
   task automatic send_cmd(logic op, logic [GEN_W-1:0] gen, logic [VAL_W-1:0] seed_in);
      req_opcode     <= op;
      req_generator  <= gen;
      req_seed_value <= seed_in;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
      if (gen < NUM_GEN) begin
         if (op == scl_pkg::OP_SEED) seed_generator(gen, seed_in);
         else draw_number(gen);
      end
   endtask

   task automatic idle_for(int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending_draws.size() != 0) @(posedge clock);
   endtask

   // Mostly back-to-back or short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [VAL_W-1:0] pick_seed();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return VAL_W'(TOP_DRAW);
         2: return ALL_ONES;
         3: return VAL_W'(MOD_TWO);
         default: return VAL_W'($urandom);
      endcase
   endfunction

   // Before any seed every generator works from a zeroed table
   task automatic test_unseeded_draws();
      for (int g = 0; g < NUM_GEN; g++) begin
         send_cmd(scl_pkg::OP_DRAW, GEN_W'(g), VAL_W'($urandom));
         send_cmd(scl_pkg::OP_DRAW, GEN_W'(g), VAL_W'($urandom));
      end
   endtask

   // An index past the bank is dropped: no result, no state change
   task automatic test_out_of_range_generator();
      send_cmd(scl_pkg::OP_SEED, NO_SUCH_GEN, ALL_ONES);
      idle_for(2);
      send_cmd(scl_pkg::OP_DRAW, NO_SUCH_GEN, '0);
      send_cmd(scl_pkg::OP_DRAW, GEN_W'(0), ALL_ONES);
   endtask

   // Zero seed, clamped seeds, and a seed equal to the second modulus
   task automatic test_seed_extremes();
      send_cmd(scl_pkg::OP_SEED, GEN_W'(0), '0);
      send_cmd(scl_pkg::OP_DRAW, GEN_W'(0), '0);
      send_cmd(scl_pkg::OP_DRAW, GEN_W'(0), '0);
      send_cmd(scl_pkg::OP_SEED, GEN_W'(1), ALL_ONES);
      send_cmd(scl_pkg::OP_DRAW, GEN_W'(1), ALL_ONES);
      send_cmd(scl_pkg::OP_DRAW, GEN_W'(1), ALL_ONES);
      send_cmd(scl_pkg::OP_SEED, GEN_W'(2), VAL_W'(MOD_TWO));
      send_cmd(scl_pkg::OP_DRAW, GEN_W'(2), '0);
      send_cmd(scl_pkg::OP_DRAW, GEN_W'(2), '0);
      send_cmd(scl_pkg::OP_SEED, GEN_W'(0), VAL_W'(TOP_DRAW));
      send_cmd(scl_pkg::OP_DRAW, GEN_W'(0), '0);
      send_cmd(scl_pkg::OP_SEED, GEN_W'(1), VAL_W'(1));
      send_cmd(scl_pkg::OP_DRAW, GEN_W'(1), '0);
   endtask

   // Long draw streams on all generators, sparse reseeds, some dropped commands.
   // Halfway through, the sender holds off until every draw is back.
   task automatic test_random_streams();
      int counted;
      int burst_left;
      int r;
      logic [GEN_W-1:0] g;
      counted = 0;
      burst_left = 0;
      while (counted < RANDOM_ITEMS) begin
         if (burst_left > 0) burst_left--;
         else if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(20, 60);
         else idle_for(pick_gap());
         r = $urandom_range(0, 99);
         g = GEN_W'($urandom_range(0, NUM_GEN - 1));
         if (r < 4) begin
            send_cmd(scl_pkg::OP_SEED, g, pick_seed());
            counted++;
         end else if (r < 9) begin
            send_cmd(logic'($urandom_range(0, 1)), NO_SUCH_GEN, VAL_W'($urandom));
         end else begin
            send_cmd(scl_pkg::OP_DRAW, g, VAL_W'($urandom));
            counted++;
         end
         if (counted == RANDOM_ITEMS / 2) begin
            wait_drained();
            counted++;
         end
      end
   endtask

   // Compare each result with the oldest predicted draw
   always @(posedge clock) begin
      draw_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_draws.size() == 0) begin
            $error("unexpected result: random_value %0d from_generator %0d",
                   rsp_random_value, rsp_from_generator);
            fail_count++;
         end else begin
            want = pending_draws.pop_front();
            if (rsp_random_value !== want.value) begin
               $error("random_value: expected %0d, actual %0d", want.value, rsp_random_value);
               fail_count++;
            end
            if (rsp_from_generator !== want.gen) begin
               $error("from_generator: expected %0d, actual %0d",
                      want.gen, rsp_from_generator);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: too long with neither a command nor a result transfer
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("shuffled_combined_lcg_bank_core: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset          <= 1'b1;
      start          <= 1'b0;
      req_opcode     <= scl_pkg::OP_DRAW;
      req_generator  <= '0;
      req_seed_value <= '0;
      clear_generators();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_unseeded_draws();
      test_out_of_range_generator();
      test_seed_extremes();
      test_random_streams();

      // Drain, let any final warm-up finish, then a short tail
      wait_drained();
      do @(posedge clock); while (busy);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending_draws.size() == 0) begin
         $display("shuffled_combined_lcg_bank_core: match");
      end else begin
         $display("shuffled_combined_lcg_bank_core: mismatch");
      end
      $finish;
   end

endmodule
